### rtl/assert_macros.svh
// Assertion macros, included by aes_encrypt_round.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/aesr_pkg.sv
// Types, S-box table and field arithmetic for the AES encryption round.
package aesr_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned NBYTES  = 16;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef struct packed {
    logic [HALF_W-1:0] block_hi;
    logic [HALF_W-1:0] block_lo;
    logic [HALF_W-1:0] round_key_hi;
    logic [HALF_W-1:0] round_key_lo;
    logic              final_round;
  } aesr_req_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_hi;
    logic [HALF_W-1:0] result_lo;
  } aesr_rsp_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

### rtl/aes_encrypt_round.sv
// Top level: one AES-128 encryption round, two-stage pipeline.
//
// Usage:
//   Drive req (state halves, round key halves, final_round) and raise start.
//   A request is taken at every rising edge with start high and busy low.
//   busy stays low: a new request may be given in every cycle.
//   Once taken, a request passes the S-box register and the output register;
//   then done is high for one cycle and result carries the new state; the
//   receiver cannot stall, so the result must be captured in that cycle.
//   Steps: registered S-box lookup, then ShiftRows/MixColumns/AddRoundKey into
//   the output register. Throughput: 1 request per cycle, set by the sixteen
//   parallel S-box lookups of the first stage.
//   final_round high skips MixColumns.
//   Reset (rst, synchronous) drops any requests in flight and clears done.
//   The S-box is a constant table and needs no loading after reset.
`include "assert_macros.svh"
module aes_encrypt_round
  import aesr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  aesr_req_t req,
  output logic      done,
  output aesr_rsp_t result
);

  logic               take;
  logic               sub_valid;
  logic [BLOCK_W-1:0] sub_state;
  logic [BLOCK_W-1:0] sub_key;
  logic               sub_last;
  logic [BLOCK_W-1:0] shifted;
  logic [BLOCK_W-1:0] mixed;
  logic [BLOCK_W-1:0] round_next;

  assign busy = 1'b0;
  assign take = start && !busy;

  aesr_sub_bytes u_sub (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .state_in  ({req.block_hi, req.block_lo}),
    .key_in    ({req.round_key_hi, req.round_key_lo}),
    .last_in   (req.final_round),
    .out_valid (sub_valid),
    .state_out (sub_state),
    .key_out   (sub_key),
    .last_out  (sub_last)
  );

  // ShiftRows: row r rotates left by r columns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[BLOCK_W-1-8*(4*c+r) -: 8] = sub_state[BLOCK_W-1-8*(4*((c+r)%4)+r) -: 8];
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = shifted[BLOCK_W-1-8*(4*c)   -: 8];
      a1  = shifted[BLOCK_W-1-8*(4*c+1) -: 8];
      a2  = shifted[BLOCK_W-1-8*(4*c+2) -: 8];
      a3  = shifted[BLOCK_W-1-8*(4*c+3) -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
      mixed[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
      mixed[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      mixed[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
  end

  assign round_next = (sub_last ? shifted : mixed) ^ sub_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sub_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.result_hi <= round_next[BLOCK_W-1:HALF_W];
    result.result_lo <= round_next[HALF_W-1:0];
  end

  `ASSERT_IMPLIES(a_never_busy, clk, rst, 1'b1, !busy)
  `ASSERT_NEXT(a_take_to_sub, clk, rst, take, sub_valid)
  `ASSERT_NEXT(a_sub_to_done, clk, rst, sub_valid, done)
  `ASSERT_NEXT(a_idle_no_sub, clk, rst, !take, !sub_valid)
  `ASSERT_NEXT(a_idle_no_done, clk, rst, !sub_valid, !done)

endmodule

### rtl/aesr_sub_bytes.sv
// SubBytes stage: sixteen registered S-box lookups, key and flag carried alongside.
module aesr_sub_bytes
  import aesr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [BLOCK_W-1:0] state_in,
  input  logic [BLOCK_W-1:0] key_in,
  input  logic               last_in,
  output logic               out_valid,
  output logic [BLOCK_W-1:0] state_out,
  output logic [BLOCK_W-1:0] key_out,
  output logic               last_out
);

  logic [BLOCK_W-1:0] sub_next;

  always_comb begin
    for (int n = 0; n < NBYTES; n++) begin
      sub_next[BLOCK_W-1-8*n -: 8] = SBOX[state_in[BLOCK_W-1-8*n -: 8]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    state_out <= sub_next;
    key_out   <= key_in;
    last_out  <= last_in;
  end

endmodule
